/* sv/buvg_pkg.sv */
`timescale 1ns / 1ps

package buvg_pkg;

    localparam int TIME_BITS     = 32;
    localparam int VOLT_BITS     = 16;
    localparam int REG_COUNT     = 7;
    localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
    localparam int CFG_DATA_BITS = (TIME_BITS > 32) ? 64 : 32;
    localparam int ADDR_LSB      = $clog2(CFG_DATA_BITS / 8);
    localparam int PADDR_BITS    = REG_IDX_BITS + ADDR_LSB;

    typedef logic [REG_IDX_BITS-1:0] t_reg_idx;

    localparam t_reg_idx REG_MONITOR_ENABLE   = t_reg_idx'(0);
    localparam t_reg_idx REG_WARN_MV          = t_reg_idx'(1);
    localparam t_reg_idx REG_CLEAR_MV         = t_reg_idx'(2);
    localparam t_reg_idx REG_CRITICAL_MV      = t_reg_idx'(3);
    localparam t_reg_idx REG_RECOVER_MV       = t_reg_idx'(4);
    localparam t_reg_idx REG_CRITICAL_HOLD_MS = t_reg_idx'(5);
    localparam t_reg_idx REG_RECOVER_HOLD_MS  = t_reg_idx'(6);

    typedef struct packed {
        logic                 monitor_enable;
        logic [VOLT_BITS-1:0] warn_mv;
        logic [VOLT_BITS-1:0] clear_mv;
        logic [VOLT_BITS-1:0] critical_mv;
        logic [VOLT_BITS-1:0] recover_mv;
        logic [TIME_BITS-1:0] critical_hold_ms;
        logic [TIME_BITS-1:0] recover_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [VOLT_BITS-1:0] voltage_mv;
        logic                 sample_ok;
        logic                 critical_is_latched;
        logic [TIME_BITS-1:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic                 warn_state;
        logic                 crit_pending;
        logic [TIME_BITS-1:0] crit_start_ms;
        logic                 recov_pending;
        logic [TIME_BITS-1:0] recov_start_ms;
    } t_state;

    typedef struct packed {
        logic warning_flag;
        logic latch_request;
        logic clear_request;
    } t_result;

endpackage

/* sv/buvg_regs.sv */
`timescale 1ns / 1ps

module buvg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [buvg_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [buvg_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [buvg_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output buvg_pkg::t_cfg                       o_cfg
);

    buvg_pkg::t_cfg   r_cfg;
    buvg_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[buvg_pkg::PADDR_BITS-1:buvg_pkg::ADDR_LSB];
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                buvg_pkg::REG_MONITOR_ENABLE: begin
                    r_cfg.monitor_enable <= pwdata[0];
                end
                buvg_pkg::REG_WARN_MV: begin
                    r_cfg.warn_mv <= pwdata[buvg_pkg::VOLT_BITS-1:0];
                end
                buvg_pkg::REG_CLEAR_MV: begin
                    r_cfg.clear_mv <= pwdata[buvg_pkg::VOLT_BITS-1:0];
                end
                buvg_pkg::REG_CRITICAL_MV: begin
                    r_cfg.critical_mv <= pwdata[buvg_pkg::VOLT_BITS-1:0];
                end
                buvg_pkg::REG_RECOVER_MV: begin
                    r_cfg.recover_mv <= pwdata[buvg_pkg::VOLT_BITS-1:0];
                end
                buvg_pkg::REG_CRITICAL_HOLD_MS: begin
                    r_cfg.critical_hold_ms <= pwdata[buvg_pkg::TIME_BITS-1:0];
                end
                buvg_pkg::REG_RECOVER_HOLD_MS: begin
                    r_cfg.recover_hold_ms <= pwdata[buvg_pkg::TIME_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            buvg_pkg::REG_MONITOR_ENABLE:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.monitor_enable);
            buvg_pkg::REG_WARN_MV:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.warn_mv);
            buvg_pkg::REG_CLEAR_MV:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.clear_mv);
            buvg_pkg::REG_CRITICAL_MV:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.critical_mv);
            buvg_pkg::REG_RECOVER_MV:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.recover_mv);
            buvg_pkg::REG_CRITICAL_HOLD_MS:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.critical_hold_ms);
            buvg_pkg::REG_RECOVER_HOLD_MS:
                prdata = buvg_pkg::CFG_DATA_BITS'(r_cfg.recover_hold_ms);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* sv/buvg_step.sv */
`timescale 1ns / 1ps

module buvg_step (
    input  buvg_pkg::t_cfg    i_cfg,
    input  buvg_pkg::t_sample i_sample,
    input  buvg_pkg::t_state  i_state,
    output buvg_pkg::t_state  o_state,
    output buvg_pkg::t_result o_result
);

    logic                           latched;
    logic                           qual;
    logic                           pending;
    logic [buvg_pkg::TIME_BITS-1:0] start_ms;
    logic [buvg_pkg::TIME_BITS-1:0] hold_ms;
    logic [buvg_pkg::TIME_BITS-1:0] elapsed;
    logic                           held;
    logic                           n_pending;
    logic                           n_restart;
    logic                           fire;

    assign latched = i_sample.critical_is_latched;

    // one shared debounce: the branch picked by the latched flag
    assign qual = latched
        ? (i_sample.sample_ok && (i_sample.voltage_mv > i_cfg.recover_mv))
        : (i_sample.sample_ok && (i_sample.voltage_mv < i_cfg.critical_mv));
    assign pending  = latched ? i_state.recov_pending   : i_state.crit_pending;
    assign start_ms = latched ? i_state.recov_start_ms  : i_state.crit_start_ms;
    assign hold_ms  = latched ? i_cfg.recover_hold_ms   : i_cfg.critical_hold_ms;
    assign elapsed  = i_sample.time_ms - start_ms;
    assign held     = (elapsed >= hold_ms);

    assign n_restart = qual && !pending;
    assign fire      = qual && pending && held;
    assign n_pending = qual && (!pending || !held);

    always_comb begin
        o_state = i_state;

        if (i_cfg.monitor_enable && i_sample.sample_ok) begin
            if (i_sample.voltage_mv < i_cfg.warn_mv) begin
                o_state.warn_state = 1'b1;
            end else if (i_sample.voltage_mv > i_cfg.clear_mv) begin
                o_state.warn_state = 1'b0;
            end
        end

        if (!latched) begin
            o_state.recov_pending = 1'b0;
            o_state.crit_pending  = n_pending;
            if (n_restart) begin
                o_state.crit_start_ms = i_sample.time_ms;
            end
        end else begin
            o_state.crit_pending  = 1'b0;
            o_state.recov_pending = n_pending;
            if (n_restart) begin
                o_state.recov_start_ms = i_sample.time_ms;
            end
        end

        o_result.warning_flag  = o_state.warn_state;
        o_result.latch_request = fire && !latched;
        o_result.clear_request = fire && latched;
    end

endmodule

/* sv/battery_undervoltage_guard_core.sv */
`timescale 1ns / 1ps

// Path: an accepted request is held in the input reg, then in the result reg.
// Throughput: one request per cycle unless an output stall backs up the input.
// Single-pass evaluation: compares plus one wrapped time subtraction.
// Reset: synchronous, active low; clears config registers, state and valids.

module battery_undervoltage_guard_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [buvg_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [buvg_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [buvg_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [buvg_pkg::VOLT_BITS-1:0]       i_voltage_mv,
    input  logic                                 i_sample_ok,
    input  logic                                 i_critical_is_latched,
    input  logic [buvg_pkg::TIME_BITS-1:0]       i_time_ms,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_warning_flag,
    output logic                                 o_latch_request,
    output logic                                 o_clear_request
);

    buvg_pkg::t_cfg    cfg;
    buvg_pkg::t_sample r_sample;
    logic              r_in_valid;
    buvg_pkg::t_state  r_state;
    buvg_pkg::t_state  n_state;
    buvg_pkg::t_result n_result;
    buvg_pkg::t_result r_result;
    logic              r_out_valid;
    logic              advance;

    buvg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    buvg_step u_step (
        .i_cfg    (cfg),
        .i_sample (r_sample),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample.voltage_mv          <= i_voltage_mv;
            r_sample.sample_ok           <= i_sample_ok;
            r_sample.critical_is_latched <= i_critical_is_latched;
            r_sample.time_ms             <= i_time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_warning_flag  = r_result.warning_flag;
    assign o_latch_request = r_result.latch_request;
    assign o_clear_request = r_result.clear_request;

endmodule

/* sv/buvg_checker.sv */
`timescale 1ns / 1ps

module buvg_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_warning_flag,
    input logic o_latch_request,
    input logic o_clear_request
);

    a_req_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_latch_request && o_clear_request))
        else $error("latch and clear requested together");

    // a fired debounce restarts, so the very next result cannot fire again
    a_latch_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_latch_request) ##1 o_out_valid
        |-> !o_latch_request)
        else $error("latch request on consecutive results");

    a_clear_no_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_clear_request) ##1 o_out_valid
        |-> !o_clear_request)
        else $error("clear request on consecutive results");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_warning_flag)
        && $stable(o_latch_request) && $stable(o_clear_request)))
        else $error("stalled result changed");

endmodule

bind battery_undervoltage_guard_core buvg_checker u_buvg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_warning_flag  (o_warning_flag),
    .o_latch_request (o_latch_request),
    .o_clear_request (o_clear_request)
);

/* bench/battery_undervoltage_guard_core_test.sv */
`timescale 1ns / 1ps

module battery_undervoltage_guard_core_test;

    localparam buvg_pkg::t_reg_idx REG_UNMAPPED = buvg_pkg::t_reg_idx'(buvg_pkg::REG_COUNT);
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 116;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [buvg_pkg::PADDR_BITS-1:0]    paddr = '0;
    logic [buvg_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [buvg_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;
    logic                               i_in_valid = 1'b0;
    logic                               o_in_ready;
    logic [buvg_pkg::VOLT_BITS-1:0]     i_voltage_mv = '0;
    logic                               i_sample_ok = 1'b0;
    logic                               i_critical_is_latched = 1'b0;
    logic [buvg_pkg::TIME_BITS-1:0]     i_time_ms = '0;
    logic                               o_out_valid;
    logic                               i_out_ready = 1'b0;
    logic                               o_warning_flag;
    logic                               o_latch_request;
    logic                               o_clear_request;

    battery_undervoltage_guard_core dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_voltage_mv          (i_voltage_mv),
        .i_sample_ok           (i_sample_ok),
        .i_critical_is_latched (i_critical_is_latched),
        .i_time_ms             (i_time_ms),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_warning_flag        (o_warning_flag),
        .o_latch_request       (o_latch_request),
        .o_clear_request       (o_clear_request)
    );

    always #5 i_clk = ~i_clk;

    buvg_pkg::t_cfg    guard_cfg = '0;
    buvg_pkg::t_state  guard_st = '0;
    buvg_pkg::t_sample pending_samples[$];
    buvg_pkg::t_result expected_flags[$];

    logic calm = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   accepted_count = 0;
    int   results_seen = 0;
    int   failures = 0;
    int   settings_count = 0;

    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic advance_hold(input logic hit, inout logic pending,
                                          inout logic [buvg_pkg::TIME_BITS-1:0] start,
                                          input logic [buvg_pkg::TIME_BITS-1:0] now,
                                          input logic [buvg_pkg::TIME_BITS-1:0] hold);
        logic [buvg_pkg::TIME_BITS-1:0] elapsed;
        elapsed = now - start;
        if (!hit) begin
            pending = 1'b0;
            return 1'b0;
        end
        if (!pending) begin
            pending = 1'b1;
            start = now;
            return 1'b0;
        end
        if (elapsed >= hold) begin
            pending = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic buvg_pkg::t_result predict_guard(input buvg_pkg::t_sample s);
        buvg_pkg::t_result r;
        r = '0;
        if (guard_cfg.monitor_enable && s.sample_ok) begin
            if (s.voltage_mv < guard_cfg.warn_mv)
                guard_st.warn_state = 1'b1;
            else if (s.voltage_mv > guard_cfg.clear_mv)
                guard_st.warn_state = 1'b0;
        end
        if (!s.critical_is_latched) begin
            guard_st.recov_pending = 1'b0;
            r.latch_request = advance_hold(s.sample_ok && s.voltage_mv < guard_cfg.critical_mv,
                                           guard_st.crit_pending, guard_st.crit_start_ms,
                                           s.time_ms, guard_cfg.critical_hold_ms);
        end else begin
            guard_st.crit_pending = 1'b0;
            r.clear_request = advance_hold(s.sample_ok && s.voltage_mv > guard_cfg.recover_mv,
                                           guard_st.recov_pending, guard_st.recov_start_ms,
                                           s.time_ms, guard_cfg.recover_hold_ms);
        end
        r.warning_flag = guard_st.warn_state;
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        buvg_pkg::t_sample s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                s.voltage_mv          = i_voltage_mv;
                s.sample_ok           = i_sample_ok;
                s.critical_is_latched = i_critical_is_latched;
                s.time_ms             = i_time_ms;
                expected_flags.push_back(predict_guard(s));
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    s = pending_samples.pop_front();
                    i_voltage_mv          <= s.voltage_mv;
                    i_sample_ok           <= s.sample_ok;
                    i_critical_is_latched <= s.critical_is_latched;
                    i_time_ms             <= s.time_ms;
                    i_in_valid            <= 1'b1;
                    send_gap = idle_len();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        buvg_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_flags.size() == 0) begin
                    $error("unexpected result: nothing pending");
                    failures++;
                end else begin
                    want = expected_flags.pop_front();
                    if (o_warning_flag !== want.warning_flag) begin
                        $error("warning_flag: expected %0b, got %0b",
                               want.warning_flag, o_warning_flag);
                        failures++;
                    end
                    if (o_latch_request !== want.latch_request) begin
                        $error("latch_request: expected %0b, got %0b",
                               want.latch_request, o_latch_request);
                        failures++;
                    end
                    if (o_clear_request !== want.clear_request) begin
                        $error("clear_request: expected %0b, got %0b",
                               want.clear_request, o_clear_request);
                        failures++;
                    end
                end
                // long output stall so the input side backs up
                if (results_seen == HOLD_OFF_AT)
                    recv_gap = HOLD_OFF_CYCLES;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = idle_len();
            end
        end
    end

    task automatic write_reg(input buvg_pkg::t_reg_idx idx,
                             input logic [buvg_pkg::CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {buvg_pkg::ADDR_LSB{1'b0}}};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            buvg_pkg::REG_MONITOR_ENABLE:
                guard_cfg.monitor_enable = value[0];
            buvg_pkg::REG_WARN_MV:
                guard_cfg.warn_mv = value[buvg_pkg::VOLT_BITS-1:0];
            buvg_pkg::REG_CLEAR_MV:
                guard_cfg.clear_mv = value[buvg_pkg::VOLT_BITS-1:0];
            buvg_pkg::REG_CRITICAL_MV:
                guard_cfg.critical_mv = value[buvg_pkg::VOLT_BITS-1:0];
            buvg_pkg::REG_RECOVER_MV:
                guard_cfg.recover_mv = value[buvg_pkg::VOLT_BITS-1:0];
            buvg_pkg::REG_CRITICAL_HOLD_MS:
                guard_cfg.critical_hold_ms = value[buvg_pkg::TIME_BITS-1:0];
            buvg_pkg::REG_RECOVER_HOLD_MS:
                guard_cfg.recover_hold_ms = value[buvg_pkg::TIME_BITS-1:0];
            default: ;
        endcase
    endtask

    // upper bits above each register's width are random junk
    task automatic program_guard(input logic en, input int warn, input int clr,
                                 input int crit, input int rec,
                                 input logic [31:0] crit_hold, input logic [31:0] rec_hold);
        write_reg(buvg_pkg::REG_MONITOR_ENABLE, {31'($urandom), en});
        write_reg(buvg_pkg::REG_WARN_MV, {16'($urandom), 16'(warn)});
        write_reg(buvg_pkg::REG_CLEAR_MV, {16'($urandom), 16'(clr)});
        write_reg(buvg_pkg::REG_CRITICAL_MV, {16'($urandom), 16'(crit)});
        write_reg(buvg_pkg::REG_RECOVER_MV, {16'($urandom), 16'(rec)});
        write_reg(buvg_pkg::REG_CRITICAL_HOLD_MS, crit_hold);
        write_reg(buvg_pkg::REG_RECOVER_HOLD_MS, rec_hold);
        settings_count++;
    endtask

    task automatic add_sample(input int mv, input logic ok, input logic latched,
                              input logic [buvg_pkg::TIME_BITS-1:0] t);
        buvg_pkg::t_sample s;
        s.voltage_mv          = buvg_pkg::VOLT_BITS'(mv);
        s.sample_ok           = ok;
        s.critical_is_latched = latched;
        s.time_ms             = t;
        pending_samples.push_back(s);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || i_in_valid || expected_flags.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic int clamp_mv(input int mv);
        if (mv < 0) return 0;
        if (mv > 65535) return 65535;
        return mv;
    endfunction

    // runs of samples with a stable latched flag and a drifting voltage,
    // salted with invalid samples and wild values
    task automatic queue_random_phase(input int center, input int count);
        logic [buvg_pkg::TIME_BITS-1:0] now;
        logic latched;
        int mv;
        int run_left;
        int r;
        now = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 + $urandom_range(255) : $urandom;
        latched = 1'($urandom_range(1));
        mv = center;
        run_left = 0;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 25);
                if ($urandom_range(2) == 0) latched = ~latched;
                mv = center + $urandom_range(800) - 400;
            end
            run_left--;
            now += $urandom_range(6);
            mv = clamp_mv(mv + $urandom_range(80) - 40);
            r = $urandom_range(99);
            if (r < 4) begin
                now = $urandom;
                add_sample($urandom_range(65535), 1'($urandom_range(1)),
                           1'($urandom_range(1)), now);
            end else if (r < 7) begin
                add_sample($urandom_range(1) ? 65535 : 0, 1'b1, latched, now);
            end else if (r < 15) begin
                add_sample(mv, 1'b0, latched, now);
            end else begin
                add_sample(mv, 1'b1, latched, now);
            end
        end
    endtask

    initial begin
        int c;
        int warn;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // crossed warning thresholds, short critical hold, zero recover hold
        program_guard(1'b1, 3300, 3000, 3000, 3600, 100, 0);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        add_sample(3200, 1, 0, 0);
        add_sample(65535, 1, 0, 10);
        add_sample(0, 1, 0, 20);
        add_sample(100, 1, 0, 50);
        add_sample(100, 1, 0, 120);
        add_sample(100, 1, 0, 130);
        add_sample(100, 0, 0, 500);
        add_sample(100, 1, 0, 600);
        add_sample(4000, 1, 0, 800);
        add_sample(100, 1, 0, 32'hFFFF_FFD0);
        add_sample(100, 1, 0, 32'h0000_0040);
        add_sample(100, 1, 1, 32'h0000_0050);
        add_sample(65535, 1, 1, 1000);
        add_sample(65535, 1, 1, 1000);
        add_sample(3700, 1, 1, 1001);
        add_sample(3700, 1, 0, 1002);
        add_sample(3700, 1, 1, 1003);
        add_sample(3700, 0, 1, 1004);
        wait_drained();

        // monitoring off, extreme thresholds and hold times
        program_guard(1'b0, 65535, 0, 65535, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_sample(0, 1, 0, 0);
        add_sample(0, 1, 0, 32'hFFFF_FFFE);
        add_sample(0, 1, 0, 32'hFFFF_FFFF);
        add_sample(65535, 1, 0, 5);
        add_sample(65535, 1, 1, 6);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            calm = (p == 5);
            c = $urandom_range(500, 6000);
            warn = c + $urandom_range(400) - 200;
            case (p)
                0: program_guard(1'b1, 0, 0, 0, 0, 0, 0);
                1: program_guard(1'b1, 65535, 65535, 65535, 65535,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                4: program_guard(1'b1, warn, warn + $urandom_range(300) - 50,
                                 c - $urandom_range(300), c + $urandom_range(300),
                                 $urandom, $urandom_range(25));
                default: program_guard(p != 3, warn, warn + $urandom_range(300) - 50,
                                       c - $urandom_range(300), c + $urandom_range(300),
                                       $urandom_range(25), $urandom_range(25));
            endcase
            @(negedge i_clk);
            queue_random_phase(c, PHASE_ITEMS);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        $display("Checked %0d results for %0d samples under %0d register settings.",
                 results_seen, accepted_count, settings_count);
        $display("Covered hysteresis, debounce start/cancel/fire, time wrap, output stall.");
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

/* battery_undervoltage_guard_core.f */
sv/buvg_pkg.sv
sv/buvg_regs.sv
sv/buvg_step.sv
sv/battery_undervoltage_guard_core.sv
sv/buvg_checker.sv
bench/battery_undervoltage_guard_core_test.sv
